[design/wsp_pkg.sv]
`default_nettype none

package wsp_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // error codes
   localparam logic [1:0] ERR_NOT_RIFF    = 2'd0;
   localparam logic [1:0] ERR_NOT_WAVE    = 2'd1;
   localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ERR_NO_DATA     = 2'd3;

   // little-endian chunk tags, first byte in bits 7:0
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] PCM_FORMAT     = 16'd1;
   localparam logic [15:0] PCM_BITS       = 16'd16;
   localparam logic [15:0] MAX_CHANNELS   = 16'd2;
   localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

   localparam logic [8:0] GAIN_RESET = 9'd128;
   localparam logic [8:0] GAIN_UNITY = 9'd256;

   localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;
   localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;

   // one parsed result, before gain
   typedef struct packed {
      logic               valid;
      kind_type           kind;
      logic signed [15:0] sample;
      logic               channel_index;
      logic [1:0]         channel_count;
      logic [1:0]         error_code;
      logic               final_sample;
   } parse_result_type;

endpackage

`default_nettype wire

[design/wsp_ifs.sv]
`default_nettype none

interface wsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface wsp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] sample_out;
   logic               channel_index;
   logic [1:0]         channel_count;
   logic [1:0]         error_code;
   logic               final_sample;

   modport source (output valid, output kind, output sample_out, output channel_index,
                   output channel_count, output error_code, output final_sample,
                   input ready);
   modport sink   (input valid, input kind, input sample_out, input channel_index,
                   input channel_count, input error_code, input final_sample,
                   output ready);
endinterface

`default_nettype wire

[design/wsp_parser.sv]
`default_nettype none

// RIFF/WAVE header walker and sample assembler; one byte per accepted item.
module wsp_parser (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [7:0]                data_byte,
   input  wire logic                      stream_end,
   output wsp_pkg::parse_result_type      result
);

   typedef enum logic [3:0] {
      PH_RIFF_TAG   = 4'd0,
      PH_RIFF_SIZE  = 4'd1,
      PH_WAVE_TAG   = 4'd2,
      PH_CHUNK_ID   = 4'd3,
      PH_CHUNK_SIZE = 4'd4,
      PH_FMT_BODY   = 4'd5,
      PH_SKIP       = 4'd6,
      PH_DATA       = 4'd7,
      PH_IDLE       = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] skip_ff, skip_in;
   logic [15:0] format_ff, format_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] chans_ff, chans_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  low_ff, low_in;
   logic        toggle_ff, toggle_in;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      tag_in    = tag_ff;
      size_in   = size_ff;
      skip_in   = skip_ff;
      format_in = format_ff;
      bits_in   = bits_ff;
      chans_in  = chans_ff;
      left_in   = left_ff;
      low_in    = low_ff;
      toggle_in = toggle_ff;
      result    = '0;

      case (phase_ff)
         PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
            tag_in = {data_byte, tag_ff[31:8]};
            if (count_ff == 4'd3) begin
               count_in = '0;
               case (phase_ff)
                  PH_RIFF_TAG: begin
                     if (tag_in != wsp_pkg::TAG_RIFF) begin
                        result.valid      = 1'b1;
                        result.kind       = wsp_pkg::KIND_ERROR;
                        result.error_code = wsp_pkg::ERR_NOT_RIFF;
                        phase_in          = PH_IDLE;
                     end else begin
                        phase_in = PH_RIFF_SIZE;
                     end
                  end
                  PH_WAVE_TAG: begin
                     if (tag_in != wsp_pkg::TAG_WAVE) begin
                        result.valid      = 1'b1;
                        result.kind       = wsp_pkg::KIND_ERROR;
                        result.error_code = wsp_pkg::ERR_NOT_WAVE;
                        phase_in          = PH_IDLE;
                     end else begin
                        phase_in = PH_CHUNK_ID;
                     end
                  end
                  default: phase_in = PH_CHUNK_SIZE;
               endcase
            end else begin
               count_in = count_ff + 4'd1;
            end
         end
         PH_RIFF_SIZE: begin
            if (count_ff == 4'd3) begin
               count_in = '0;
               phase_in = PH_WAVE_TAG;
            end else begin
               count_in = count_ff + 4'd1;
            end
         end
         PH_CHUNK_SIZE: begin
            size_in = {data_byte, size_ff[31:8]};
            if (count_ff == 4'd3) begin
               count_in = '0;
               if (tag_ff == wsp_pkg::TAG_FMT) begin
                  if (size_in < wsp_pkg::FMT_BODY_BYTES) begin
                     result.valid      = 1'b1;
                     result.kind       = wsp_pkg::KIND_ERROR;
                     result.error_code = wsp_pkg::ERR_UNSUPPORTED;
                     phase_in          = PH_IDLE;
                  end else begin
                     skip_in  = size_in - wsp_pkg::FMT_BODY_BYTES;
                     phase_in = PH_FMT_BODY;
                  end
               end else if (tag_ff == wsp_pkg::TAG_DATA) begin
                  left_in              = size_in;
                  toggle_in            = 1'b0;
                  result.valid         = 1'b1;
                  result.kind          = wsp_pkg::KIND_DATA;
                  result.channel_count = chans_ff[1:0];
                  phase_in             = PH_DATA;
               end else begin
                  skip_in  = size_in;
                  phase_in = (size_in != '0) ? PH_SKIP : PH_CHUNK_ID;
               end
            end else begin
               count_in = count_ff + 4'd1;
            end
         end
         PH_FMT_BODY: begin
            case (count_ff)
               4'd0:    format_in = {format_ff[15:8], data_byte};
               4'd1:    format_in = {data_byte, format_ff[7:0]};
               4'd2:    chans_in  = {chans_ff[15:8], data_byte};
               4'd3:    chans_in  = {data_byte, chans_ff[7:0]};
               4'd14:   bits_in   = {bits_ff[15:8], data_byte};
               4'd15:   bits_in   = {data_byte, bits_ff[7:0]};
               default: ;
            endcase
            count_in = count_ff + 4'd1;
            if (count_ff == 4'd15) begin
               if (format_in != wsp_pkg::PCM_FORMAT || bits_in != wsp_pkg::PCM_BITS ||
                   chans_in > wsp_pkg::MAX_CHANNELS) begin
                  result.valid      = 1'b1;
                  result.kind       = wsp_pkg::KIND_ERROR;
                  result.error_code = wsp_pkg::ERR_UNSUPPORTED;
                  phase_in          = PH_IDLE;
               end else begin
                  phase_in = (skip_ff != '0) ? PH_SKIP : PH_CHUNK_ID;
               end
            end
         end
         PH_SKIP: begin
            if (skip_ff != '0) begin
               skip_in = skip_ff - 32'd1;
            end
            if (skip_in == '0) begin
               phase_in = PH_CHUNK_ID;
            end
         end
         PH_DATA: begin
            if (left_ff != '0) begin
               left_in = left_ff - 32'd1;
               if (!count_ff[0]) begin
                  low_in   = data_byte;
                  count_in = 4'd1;
               end else begin
                  count_in             = '0;
                  result.valid         = 1'b1;
                  result.kind          = wsp_pkg::KIND_SAMPLE;
                  result.sample        = {data_byte, low_ff};
                  result.channel_index = toggle_ff;
                  result.final_sample  = (left_in[31:1] == '0);
                  toggle_in            = (chans_ff == wsp_pkg::MAX_CHANNELS) ? ~toggle_ff
                                                                              : 1'b0;
               end
            end
         end
         default: ;
      endcase

      if (stream_end) begin
         // truncated file: report what was missing
         if (!result.valid && phase_in != PH_DATA && phase_in != PH_IDLE) begin
            result.valid = 1'b1;
            result.kind  = wsp_pkg::KIND_ERROR;
            case (phase_in)
               PH_RIFF_TAG:               result.error_code = wsp_pkg::ERR_NOT_RIFF;
               PH_RIFF_SIZE, PH_WAVE_TAG: result.error_code = wsp_pkg::ERR_NOT_WAVE;
               default:                   result.error_code = wsp_pkg::ERR_NO_DATA;
            endcase
         end
         phase_in  = PH_RIFF_TAG;
         count_in  = '0;
         tag_in    = '0;
         size_in   = '0;
         skip_in   = '0;
         format_in = '0;
         bits_in   = '0;
         chans_in  = '0;
         left_in   = '0;
         low_in    = '0;
         toggle_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_RIFF_TAG;
         count_ff  <= '0;
         tag_ff    <= '0;
         size_ff   <= '0;
         skip_ff   <= '0;
         format_ff <= '0;
         bits_ff   <= '0;
         chans_ff  <= '0;
         left_ff   <= '0;
         low_ff    <= '0;
         toggle_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         tag_ff    <= tag_in;
         size_ff   <= size_in;
         skip_ff   <= skip_in;
         format_ff <= format_in;
         bits_ff   <= bits_in;
         chans_ff  <= chans_in;
         left_ff   <= left_in;
         low_ff    <= low_in;
         toggle_ff <= toggle_in;
      end
   end

   // file end always restarts the parse
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && stream_end |=> phase_ff == PH_RIFF_TAG && count_ff == '0 && chans_ff == '0)
      else $error("parser not restarted after stream end");

   // samples only come out of the data chunk
   a_sample_in_data: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.kind == wsp_pkg::KIND_SAMPLE |-> phase_ff == PH_DATA)
      else $error("sample outside data chunk");

   // exhausted data chunk yields nothing but a possible restart
   a_data_done_quiet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA && left_ff == '0 |-> !result.valid)
      else $error("result after data chunk ended");

endmodule

`default_nettype wire

[design/wsp_scale.sv]
`default_nettype none

// sample * gain / 256, truncated toward zero, clamped to 16 bits
module wsp_scale (
   input  wire logic signed [15:0] sample,
   input  wire logic [8:0]         gain,
   output      logic signed [15:0] scaled
);

   logic [8:0]         gain_eff;
   logic signed [25:0] product;
   logic signed [25:0] biased;
   logic signed [17:0] quot;

   always_comb begin
      gain_eff = gain[8] ? wsp_pkg::GAIN_UNITY : gain;
      product  = sample * $signed({1'b0, gain_eff});
      // negative products round up before the shift
      biased   = product + (product[25] ? 26'sd255 : 26'sd0);
      quot     = biased[25:8];
      if (quot > wsp_pkg::SAMPLE_MAX) begin
         scaled = wsp_pkg::SAMPLE_MAX[15:0];
      end else if (quot < wsp_pkg::SAMPLE_MIN) begin
         scaled = wsp_pkg::SAMPLE_MIN[15:0];
      end else begin
         scaled = quot[15:0];
      end
   end

endmodule

`default_nettype wire

[design/wav_stream_parse_and_gain.sv]
// WAV byte-stream parser with 16-bit PCM volume control.
// req_chan: one file byte per item (data_byte) plus stream_end on the last
//    byte. The parser checks RIFF/WAVE, walks chunks, validates the fmt chunk
//    and then turns each little-endian sample pair into one scaled sample.
// rsp_chan: zero or one item per input byte: kind 1 when the data chunk is
//    found (with channel_count), kind 0 per scaled sample (channel_index,
//    final_sample), kind 2 on error (error_code).
// csr_wr_en/csr_wr_data: gain in 1/256 steps, 256 is unity, larger acts as
//    256. Write only while the block is idle.
// Throughput: one byte per cycle while the output is not stalled. The parser
//    state advances on the accept edge; the result goes into a stage register
//    and the gain multiply sits between that register and the output register.
// Path: a result is caught in the stage register at the byte's accept edge,
//    then shows on rsp_chan.valid from the output register until taken.
// Stall: the two registers form a pipeline; while rsp_chan.ready is low an
//    empty stage keeps taking bytes until one yields a result, then
//    req_chan.ready drops.
// Reset: parser back to expecting a RIFF tag, gain to 128, pipeline empty.
//    stream_end also restarts the parser (gain kept).
`default_nettype none

module wav_stream_parse_and_gain (
   input  wire logic   clock,
   input  wire logic   reset,
   wsp_req_if.sink     req_chan,
   wsp_rsp_if.source   rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [8:0] csr_wr_data
);

   logic [8:0] gain_ff;

   wsp_pkg::parse_result_type parsed;
   wsp_pkg::parse_result_type stage_ff, stage_in;
   logic                      stage_valid_ff;

   logic               out_valid_ff;
   logic [1:0]         out_kind_ff;
   logic signed [15:0] out_sample_ff;
   logic               out_index_ff;
   logic [1:0]         out_count_ff;
   logic [1:0]         out_error_ff;
   logic               out_final_ff;

   logic               accept;
   logic               out_load;
   logic               stage_load;
   logic signed [15:0] scaled;

   // output register frees on take; stage frees when it moves on
   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign stage_load     = !stage_valid_ff || out_load;
   assign req_chan.ready = stage_load;
   assign accept         = req_chan.valid && stage_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= wsp_pkg::GAIN_RESET;
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   wsp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_chan.data_byte),
      .stream_end (req_chan.stream_end),
      .result     (parsed)
   );

   // byte with no result leaves a bubble
   always_comb begin
      stage_in       = parsed;
      stage_in.valid = accept && parsed.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (stage_load) begin
         stage_valid_ff <= stage_in.valid;
      end
      if (stage_load) begin
         stage_ff <= stage_in;
      end
   end

   wsp_scale u_scale (
      .sample (stage_ff.sample),
      .gain   (gain_ff),
      .scaled (scaled)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= stage_valid_ff;
      end
      if (out_load) begin
         out_kind_ff   <= stage_ff.kind;
         out_sample_ff <= scaled;
         out_index_ff  <= stage_ff.channel_index;
         out_count_ff  <= stage_ff.channel_count;
         out_error_ff  <= stage_ff.error_code;
         out_final_ff  <= stage_ff.final_sample;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_kind_ff;
   assign rsp_chan.sample_out    = out_sample_ff;
   assign rsp_chan.channel_index = out_index_ff;
   assign rsp_chan.channel_count = out_count_ff;
   assign rsp_chan.error_code    = out_error_ff;
   assign rsp_chan.final_sample  = out_final_ff;

   // a full stage held behind a stalled output keeps its item
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !out_load |=> stage_valid_ff && $stable(stage_ff))
      else $error("pipeline stage lost an item under stall");

   // nothing enters while both registers are full and stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && out_valid_ff && !rsp_chan.ready |-> !accept)
      else $error("byte accepted into a full pipeline");

endmodule

`default_nettype wire
